@@ src/pfet_pkg.sv @@
package pfet_pkg;

  localparam int REQ_BITS          = 3;
  localparam int HANDLE_FIELD_BITS = 32;
  localparam int INDEX_BITS        = 4;
  localparam int TOTAL_BITS        = 4;
  localparam int STATUS_BITS       = 2;

  localparam logic [REQ_BITS-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_PIN    = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_UNPIN  = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 3'd4;
  localparam logic [REQ_BITS-1:0] REQ_READ   = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_PIN_LIMIT = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    PTR_KEEP = 2'd0,
    PTR_ZERO = 2'd1,
    PTR_IDX  = 2'd2,
    PTR_INC  = 2'd3
  } ptr_op_t;

  typedef struct packed {
    logic                   accept;
    ptr_op_t                ptr_op;
    logic                   rd_next;
    logic                   set_status;
    logic [STATUS_BITS-1:0] status_code;
    logic                   pin_set;
    logic                   pin_clr;
    logic                   tbl_clear;
    logic                   delete;
    logic                   cap_evict;
    logic                   cap_read;
    logic                   mem_move;
    logic                   append;
    logic                   out_load;
  } pfet_cmd_t;

  typedef struct packed {
    logic                in_valid;
    logic                out_free;
    logic [REQ_BITS-1:0] req;
    logic                full;
    logic                count_zero;
    logic                pin_limit;
    logic                idx_ok;
    logic                ptr_pinned;
    logic                ptr_last;
    logic                ptr_below;
    logic                match;
  } pfet_stat_t;

endpackage

@@ src/pfet_ifs.sv @@
interface pfet_req_if import pfet_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [REQ_BITS-1:0]          req_type;
  logic [HANDLE_FIELD_BITS-1:0] item_handle;
  logic [INDEX_BITS-1:0]        entry_index;

  modport source(output valid, req_type, item_handle, entry_index, input ready);
  modport sink(input valid, req_type, item_handle, entry_index, output ready);
endinterface

interface pfet_rsp_if import pfet_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [HANDLE_FIELD_BITS-1:0] read_handle;
  logic                         read_pinned;
  logic [TOTAL_BITS-1:0]        entry_total;
  logic                         evicted_valid;
  logic [HANDLE_FIELD_BITS-1:0] evicted_handle;
  logic [STATUS_BITS-1:0]       status;

  modport source(output valid, read_handle, read_pinned, entry_total, evicted_valid,
                 evicted_handle, status, input ready);
  modport sink(input valid, read_handle, read_pinned, entry_total, evicted_valid,
               evicted_handle, status, output ready);
endinterface

@@ src/pinned_fifo_entry_table_core.sv @@
// channel | dir | fields
// req     | in  | req_type, item_handle, entry_index
// rsp     | out | read_handle, read_pinned, entry_total, evicted_valid, evicted_handle, status
//
// one request at a time; pin, unpin, clear, unknown and rejected requests go decode then done
// read: decode, fetch, readout, done; add to a non-full table: decode, append, done
// add to a full table: scan pin bits (one pin bit a cycle), fetch, evict, shift/move per entry
// moved, append, done; remove: fetch and compare per entry, on a hit shift/move, on a miss done
// rst is synchronous; table is empty after reset, no clearing pass
// a waiting response holds in its register; the next request is taken meanwhile and waits in its
// last cycle until the register frees
module pinned_fifo_entry_table_core import pfet_pkg::*; #(
  parameter int CAPACITY    = 10,
  parameter int HANDLE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  pfet_req_if.sink   req,
  pfet_rsp_if.source rsp
);

  pfet_cmd_t  cmd;
  pfet_stat_t st;

  pfet_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  pfet_datapath #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .st  (st)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while another is in work");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> !st.full)
    else $error("append into a full table");

  a_delete_inside: assert property (@(posedge clk) disable iff (rst)
    cmd.delete |-> st.ptr_below && !st.count_zero)
    else $error("delete outside the table");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("response overwritten before taken");

endmodule

@@ src/pfet_ctrl.sv @@
module pfet_ctrl import pfet_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  pfet_stat_t st,
  output pfet_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_VSCAN  = 11'b000_0000_0100,
    S_FETCH  = 11'b000_0000_1000,
    S_EVICT  = 11'b000_0001_0000,
    S_CMP    = 11'b000_0010_0000,
    S_SHIFT  = 11'b000_0100_0000,
    S_MOVE   = 11'b000_1000_0000,
    S_APPEND = 11'b001_0000_0000,
    S_RDOUT  = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept = 1'b1;
        if (st.in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_DONE;
        unique case (st.req)
          REQ_ADD: begin
            if (st.full) begin
              cmd.ptr_op = PTR_ZERO;
              state_next = S_VSCAN;
            end else begin
              state_next = S_APPEND;
            end
          end
          REQ_PIN: begin
            cmd.set_status = 1'b1;
            if (st.pin_limit) begin
              cmd.status_code = ST_PIN_LIMIT;
            end else if (st.idx_ok) begin
              cmd.status_code = ST_OK;
              cmd.pin_set     = 1'b1;
            end else begin
              cmd.status_code = ST_RANGE;
            end
          end
          REQ_UNPIN: begin
            if (st.idx_ok) begin
              cmd.pin_clr = 1'b1;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end
          end
          REQ_REMOVE: begin
            if (st.count_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NOT_FOUND;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              state_next = S_FETCH;
            end
          end
          REQ_CLEAR: cmd.tbl_clear = 1'b1;
          REQ_READ: begin
            if (st.idx_ok) begin
              cmd.ptr_op = PTR_IDX;
              state_next = S_FETCH;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_VSCAN: begin
        if (!st.ptr_pinned) begin
          state_next = S_FETCH;
        end else if (st.ptr_last) begin
          // every entry pinned: oldest goes
          cmd.ptr_op = PTR_ZERO;
          state_next = S_FETCH;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_FETCH: begin
        if (st.req == REQ_ADD) begin
          state_next = S_EVICT;
        end else if (st.req == REQ_REMOVE) begin
          state_next = S_CMP;
        end else begin
          state_next = S_RDOUT;
        end
      end
      S_EVICT: begin
        cmd.cap_evict = 1'b1;
        cmd.delete    = 1'b1;
        state_next    = S_SHIFT;
      end
      S_CMP: begin
        if (st.match) begin
          cmd.delete = 1'b1;
          state_next = S_SHIFT;
        end else if (st.ptr_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_next = S_FETCH;
        end
      end
      S_SHIFT: begin
        if (st.ptr_below) begin
          cmd.rd_next = 1'b1;
          state_next  = S_MOVE;
        end else if (st.req == REQ_ADD) begin
          state_next = S_APPEND;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MOVE: begin
        cmd.mem_move = 1'b1;
        cmd.ptr_op   = PTR_INC;
        state_next   = S_SHIFT;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_DONE;
      end
      S_RDOUT: begin
        cmd.cap_read = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/pfet_datapath.sv @@
module pfet_datapath import pfet_pkg::*; #(
  parameter int CAPACITY    = 10,
  parameter int HANDLE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  pfet_req_if.sink   req,
  pfet_rsp_if.source rsp,
  input  pfet_cmd_t  cmd,
  output pfet_stat_t st
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
  localparam int SW   = (HANDLE_BITS < HANDLE_FIELD_BITS) ? HANDLE_BITS : HANDLE_FIELD_BITS;

  logic [SW-1:0]          mem [CAPACITY];
  logic [SW-1:0]          rd_data;
  logic [SW-1:0]          handle_q;
  logic [REQ_BITS-1:0]    req_q;
  logic [INDEX_BITS-1:0]  idx_q;
  logic [CW-1:0]          ptr, count, pin_total;
  logic [CAPACITY-1:0]    pins;
  logic [STATUS_BITS-1:0] res_status;
  logic [SW-1:0]          res_rd_handle, res_ev_handle;
  logic                   res_rd_pin, res_ev_valid;
  logic                   out_valid;
  logic [SW-1:0]          o_rd_handle, o_ev_handle;
  logic                   o_rd_pin, o_ev_valid;
  logic [TOTAL_BITS-1:0]  o_total;
  logic [STATUS_BITS-1:0] o_status;

  logic [AW-1:0]       ptr_a, count_a, idx_a, rd_addr_a;
  logic [CW-1:0]       ptr_inc, rd_addr;
  logic [CAPACITY-1:0] lo_mask, pins_del;
  logic                accept;

  assign accept    = req.valid && cmd.accept;
  assign ptr_a     = ptr[AW-1:0];
  assign count_a   = count[AW-1:0];
  assign idx_a     = AW'(idx_q);
  assign ptr_inc   = ptr + CW'(1);
  assign rd_addr   = ptr + CW'(cmd.rd_next);
  assign rd_addr_a = rd_addr[AW-1:0];

  // close the gap at ptr
  assign lo_mask  = (CAPACITY'(1) << ptr_a) - CAPACITY'(1);
  assign pins_del = (pins & lo_mask) | ((pins >> 1) & ~lo_mask);

  assign st.in_valid   = req.valid;
  assign st.out_free   = !out_valid || rsp.ready;
  assign st.req        = req_q;
  assign st.full       = count >= CW'(CAPACITY);
  assign st.count_zero = count == '0;
  assign st.pin_limit  = pin_total >= CW'(CAPACITY - 1);
  assign st.idx_ok     = CMPW'(idx_q) < CMPW'(count);
  assign st.ptr_pinned = pins[ptr_a];
  assign st.ptr_last   = ptr_inc >= count;
  assign st.ptr_below  = ptr < count;
  assign st.match      = rd_data == handle_q;

  assign req.ready          = cmd.accept;
  assign rsp.valid          = out_valid;
  assign rsp.read_handle    = HANDLE_FIELD_BITS'(o_rd_handle);
  assign rsp.read_pinned    = o_rd_pin;
  assign rsp.entry_total    = o_total;
  assign rsp.evicted_valid  = o_ev_valid;
  assign rsp.evicted_handle = HANDLE_FIELD_BITS'(o_ev_handle);
  assign rsp.status         = o_status;

  // handle store, one read and one write port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr_a];
    if (cmd.mem_move) begin
      mem[ptr_a] <= rd_data;
    end else if (cmd.append) begin
      mem[count_a] <= handle_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pins      <= '0;
      pin_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.tbl_clear) begin
        count     <= '0;
        pins      <= '0;
        pin_total <= '0;
      end else if (cmd.delete) begin
        pins  <= pins_del;
        count <= count - CW'(1);
        if (pins[ptr_a]) pin_total <= pin_total - CW'(1);
      end else if (cmd.append) begin
        pins[count_a] <= 1'b0;
        count         <= count + CW'(1);
      end else if (cmd.pin_set) begin
        if (!pins[idx_a]) begin
          pins[idx_a] <= 1'b1;
          pin_total   <= pin_total + CW'(1);
        end
      end else if (cmd.pin_clr) begin
        if (pins[idx_a]) begin
          pins[idx_a] <= 1'b0;
          pin_total   <= pin_total - CW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q         <= req.req_type;
      handle_q      <= req.item_handle[SW-1:0];
      idx_q         <= req.entry_index;
      res_status    <= ST_OK;
      res_rd_handle <= '0;
      res_rd_pin    <= 1'b0;
      res_ev_valid  <= 1'b0;
      res_ev_handle <= '0;
    end
    case (cmd.ptr_op)
      PTR_ZERO: ptr <= '0;
      PTR_IDX:  ptr <= CW'(idx_q);
      PTR_INC:  ptr <= ptr_inc;
      default:  ptr <= ptr;
    endcase
    if (cmd.set_status) res_status <= cmd.status_code;
    if (cmd.cap_evict) begin
      res_ev_valid  <= 1'b1;
      res_ev_handle <= rd_data;
    end
    if (cmd.cap_read) begin
      res_rd_handle <= rd_data;
      res_rd_pin    <= pins[ptr_a];
    end
    if (cmd.out_load) begin
      o_rd_handle <= res_rd_handle;
      o_rd_pin    <= res_rd_pin;
      o_total     <= TOTAL_BITS'(count);
      o_ev_valid  <= res_ev_valid;
      o_ev_handle <= res_ev_handle;
      o_status    <= res_status;
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import pfet_pkg::*;

  localparam int CAPACITY     = 10;
  localparam int RANDOM_REQS  = 1600;
  localparam int QUIET_REQS   = 200;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [REQ_BITS-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_BITS-1:0] REQ_SPARE_B = 3'd7;

  typedef struct packed {
    logic [HANDLE_FIELD_BITS-1:0] rd_handle;
    logic                         rd_pin;
    logic [TOTAL_BITS-1:0]        total;
    logic                         ev_valid;
    logic [HANDLE_FIELD_BITS-1:0] ev_handle;
    logic [STATUS_BITS-1:0]       status;
  } table_rsp_t;

  typedef struct packed {
    logic [REQ_BITS-1:0]          op;
    logic [HANDLE_FIELD_BITS-1:0] handle;
    logic [INDEX_BITS-1:0]        idx;
    logic [4:0]                   reps;
    logic                         typed;
    table_rsp_t                   want;
  } plan_row_t;

  localparam table_rsp_t NO_CHECK = '0;

  // handle and index step by one on repeated rows
  localparam plan_row_t PLAN [17] = '{
    '{REQ_READ,    32'h0,        4'd0,  5'd1,  1'b1, '{32'h0, 1'b0, 4'd0, 1'b0, 32'h0, ST_RANGE}},
    '{REQ_REMOVE,  32'h0,        4'd0,  5'd1,  1'b1,
      '{32'h0, 1'b0, 4'd0, 1'b0, 32'h0, ST_NOT_FOUND}},
    '{REQ_SPARE_A, 32'hffffffff, 4'd15, 5'd1,  1'b1, '{32'h0, 1'b0, 4'd0, 1'b0, 32'h0, ST_OK}},
    '{REQ_ADD,     32'hffffffff, 4'd0,  5'd10, 1'b0, NO_CHECK},
    '{REQ_PIN,     32'h0,        4'd0,  5'd9,  1'b0, NO_CHECK},
    '{REQ_PIN,     32'h0,        4'd9,  5'd1,  1'b1,
      '{32'h0, 1'b0, 4'd10, 1'b0, 32'h0, ST_PIN_LIMIT}},
    '{REQ_PIN,     32'h0,        4'd15, 5'd1,  1'b1,
      '{32'h0, 1'b0, 4'd10, 1'b0, 32'h0, ST_PIN_LIMIT}},
    '{REQ_ADD,     32'ha5a5a5a5, 4'd0,  5'd1,  1'b1, '{32'h0, 1'b0, 4'd10, 1'b1, 32'h8, ST_OK}},
    '{REQ_READ,    32'h0,        4'd9,  5'd1,  1'b0, NO_CHECK},
    '{REQ_READ,    32'h0,        4'd15, 5'd1,  1'b1, '{32'h0, 1'b0, 4'd10, 1'b0, 32'h0, ST_RANGE}},
    '{REQ_UNPIN,   32'h0,        4'd15, 5'd1,  1'b1, '{32'h0, 1'b0, 4'd10, 1'b0, 32'h0, ST_RANGE}},
    '{REQ_UNPIN,   32'h0,        4'd0,  5'd1,  1'b0, NO_CHECK},
    '{REQ_REMOVE,  32'h0,        4'd0,  5'd1,  1'b0, NO_CHECK},
    '{REQ_REMOVE,  32'h12345678, 4'd0,  5'd1,  1'b1,
      '{32'h0, 1'b0, 4'd9, 1'b0, 32'h0, ST_NOT_FOUND}},
    '{REQ_SPARE_B, 32'h0,        4'd0,  5'd1,  1'b1, '{32'h0, 1'b0, 4'd9, 1'b0, 32'h0, ST_OK}},
    '{REQ_CLEAR,   32'h0,        4'd0,  5'd1,  1'b1, '{32'h0, 1'b0, 4'd0, 1'b0, 32'h0, ST_OK}},
    '{REQ_READ,    32'h0,        4'd0,  5'd1,  1'b1, '{32'h0, 1'b0, 4'd0, 1'b0, 32'h0, ST_RANGE}}
  };

  logic clk;
  logic rst;
  logic quiet;
  logic cur_typed;
  table_rsp_t cur_want;
  table_rsp_t rsp_due [$];
  int errors;
  int cycles;

  logic [HANDLE_FIELD_BITS-1:0] tbl_handle [CAPACITY];
  logic                         tbl_pin [CAPACITY];
  int                           tbl_count;

  pfet_req_if req_ch ();
  pfet_rsp_if rsp_ch ();

  pinned_fifo_entry_table_core #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_FIELD_BITS)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void drop_slot(input int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_handle[i] = tbl_handle[i+1];
      tbl_pin[i]    = tbl_pin[i+1];
    end
    tbl_count--;
    tbl_handle[tbl_count] = '0;
    tbl_pin[tbl_count]    = 1'b0;
  endfunction

  function automatic table_rsp_t table_update(input logic [REQ_BITS-1:0] op,
                                              input logic [HANDLE_FIELD_BITS-1:0] h,
                                              input logic [INDEX_BITS-1:0] idx);
    table_rsp_t r;
    int pins;
    int victim;
    bit hit;
    r      = '0;
    pins   = 0;
    victim = 0;
    hit    = 1'b0;
    case (op)
      REQ_ADD: begin
        if (tbl_count >= CAPACITY) begin
          // oldest unpinned entry, else the oldest
          for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!tbl_pin[i]) victim = i;
          end
          r.ev_valid  = 1'b1;
          r.ev_handle = tbl_handle[victim];
          drop_slot(victim);
        end
        tbl_handle[tbl_count] = h;
        tbl_pin[tbl_count]    = 1'b0;
        tbl_count++;
      end
      REQ_PIN: begin
        for (int i = 0; i < tbl_count; i++) pins += int'(tbl_pin[i]);
        if (pins >= CAPACITY - 1) r.status = ST_PIN_LIMIT;
        else if (int'(idx) < tbl_count) tbl_pin[idx] = 1'b1;
        else r.status = ST_RANGE;
      end
      REQ_UNPIN: begin
        if (int'(idx) < tbl_count) tbl_pin[idx] = 1'b0;
        else r.status = ST_RANGE;
      end
      REQ_REMOVE: begin
        for (int i = 0; i < tbl_count && !hit; i++) begin
          if (tbl_handle[i] == h) begin
            drop_slot(i);
            hit = 1'b1;
          end
        end
        if (!hit) r.status = ST_NOT_FOUND;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) tbl_pin[i] = 1'b0;
        tbl_count = 0;
      end
      REQ_READ: begin
        if (int'(idx) < tbl_count) begin
          r.rd_handle = tbl_handle[idx];
          r.rd_pin    = tbl_pin[idx];
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    r.total = TOTAL_BITS'(tbl_count);
    return r;
  endfunction

  task automatic send_req(input logic [REQ_BITS-1:0] op,
                          input logic [HANDLE_FIELD_BITS-1:0] h,
                          input logic [INDEX_BITS-1:0] idx,
                          input logic typed,
                          input table_rsp_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= op;
    req_ch.item_handle <= h;
    req_ch.entry_index <= idx;
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_pending();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (rsp_due.size() != 0);
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    table_rsp_t want;
    table_rsp_t got;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        want = table_update(req_ch.req_type, req_ch.item_handle, req_ch.entry_index);
        if (cur_typed) want = cur_want;
        rsp_due = {rsp_due, want};
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rd_handle: rsp_ch.read_handle, rd_pin: rsp_ch.read_pinned,
                total: rsp_ch.entry_total, ev_valid: rsp_ch.evicted_valid,
                ev_handle: rsp_ch.evicted_handle, status: rsp_ch.status};
        if (rsp_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected response: hnd=%h pin=%b tot=%0d ev=%b evh=%h st=%0d",
                     got.rd_handle, got.rd_pin, got.total, got.ev_valid, got.ev_handle,
                     got.status);
        end else begin
          want = rsp_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"response mismatch:\n  exp hnd=%h pin=%b tot=%0d ev=%b evh=%h st=%0d",
                        "\n  got hnd=%h pin=%b tot=%0d ev=%b evh=%h st=%0d"},
                       want.rd_handle, want.rd_pin, want.total, want.ev_valid,
                       want.ev_handle, want.status, got.rd_handle, got.rd_pin, got.total,
                       got.ev_valid, got.ev_handle, got.status);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    logic [REQ_BITS-1:0] op;
    logic [HANDLE_FIELD_BITS-1:0] h;
    logic [INDEX_BITS-1:0] idx;
    rst                = 1'b1;
    quiet              = 1'b0;
    errors             = 0;
    cycles             = 0;
    tbl_count          = 0;
    cur_typed          = 1'b0;
    cur_want           = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_READ;
    req_ch.item_handle = '0;
    req_ch.entry_index = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tbl_handle[i] = '0;
      tbl_pin[i]    = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (PLAN[r]) begin
      for (int k = 0; k < int'(PLAN[r].reps); k++)
        send_req(PLAN[r].op, PLAN[r].handle + HANDLE_FIELD_BITS'(k),
                 PLAN[r].idx + INDEX_BITS'(k), PLAN[r].typed, PLAN[r].want);
    end
    drain_pending();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 2) drain_pending();
      if (n == RANDOM_REQS - QUIET_REQS) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 36) op = REQ_ADD;
      else if (pick < 52) op = REQ_PIN;
      else if (pick < 62) op = REQ_UNPIN;
      else if (pick < 77) op = REQ_REMOVE;
      else if (pick < 79) op = REQ_CLEAR;
      else if (pick < 97) op = REQ_READ;
      else if (pick < 98) op = REQ_SPARE_A;
      else op = REQ_SPARE_B;
      // removes mostly target a live handle; a small pool makes duplicates
      pick = $urandom_range(0, 9);
      if (tbl_count > 0 && (pick < 3 || (op == REQ_REMOVE && pick < 8)))
        h = tbl_handle[$urandom_range(0, tbl_count - 1)];
      else if (pick < 6) h = HANDLE_FIELD_BITS'($urandom_range(0, 15));
      else h = $urandom;
      if (tbl_count > 0 && $urandom_range(0, 4) != 0)
        idx = INDEX_BITS'($urandom_range(0, tbl_count - 1));
      else idx = INDEX_BITS'($urandom_range(0, 15));
      send_req(op, h, idx, 1'b0, NO_CHECK);
    end
    drain_pending();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0 && rsp_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
